// ===== design/deque_with_reverse_top_macros.svh =====
// assertion macros for the deque block
`ifndef DEQUE_WITH_REVERSE_TOP_MACROS_SVH
`define DEQUE_WITH_REVERSE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked only outside reset
`define DQR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deque check failed");
// checked on every edge, reset included
`define DQR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("deque check failed");
`else
`define DQR_ASSERT(lbl, prop)
`define DQR_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/dqr_pkg.sv =====
`timescale 1ns / 1ps
package dqr_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned ReqWidth     = 3;
  localparam int unsigned TotalWidth   = 5;
  localparam int unsigned StatusWidth  = 2;
  localparam int unsigned OutWidth     =
    2 * ValueWidth + 1 + TotalWidth + StatusWidth;

  typedef enum logic [ReqWidth-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REVERSE    = 3'd4,
    REQ_CLEAR      = 3'd5,
    REQ_PEEK       = 3'd6
  } req_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL_DROP = 2'd1,
    ST_EMPTY_POP = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_READ = 2'd1,
    FSM_RESP = 2'd2
  } fsm_e;

endpackage

// ===== design/deque_with_reverse_top.sv =====
`timescale 1ns / 1ps
// bounded deque of 64-bit values in a ring buffer memory, with a reverse flag
// each accepted request passes the idle (update/write), read (memory read) and resp (result load)
// states in turn; a new request is taken only back in idle, once the result slot is free or being read
// the result beat is registered after the single memory read of the head and tail after each update
// reset: asynchronous active low; empty, head slot 0, normal order
module deque_with_reverse_top #(
  parameter int unsigned DEPTH = dqr_pkg::DefaultDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // item_value
  input  logic [dqr_pkg::ValueWidth-1:0] s_axis_tdata,
  // req_type
  input  logic [dqr_pkg::ReqWidth-1:0] s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // front_value, back_value, is_empty, entry_total, status
  output logic [dqr_pkg::OutWidth-1:0] m_axis_tdata
);

  `include "deque_with_reverse_top_macros.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  dqr_pkg::fsm_e    state_q, state_d;
  dqr_pkg::status_e status_q, status_d;
  logic [AW-1:0]    first_q, first_d;
  logic [CW-1:0]    count_q, count_d;
  logic             rev_q, rev_d;
  logic             m_valid_q, m_valid_d;
  logic [dqr_pkg::OutWidth-1:0] out_q, out_d;

  dqr_pkg::req_e    req;
  logic             accept;
  logic             full, empty;
  logic             at_head;
  logic [AW-1:0]    prev_first, next_first;
  logic [SW-1:0]    push_sum, last_sum;
  logic [AW-1:0]    push_slot, last_slot;
  logic             wr_en, rd_en;
  logic [AW-1:0]    wr_addr;
  logic [dqr_pkg::ValueWidth-1:0] head_val, tail_val, front_val, back_val;

  assign req    = dqr_pkg::req_e'(s_axis_tuser);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  // ring pointer arithmetic
  assign prev_first = (first_q == '0) ? AW'(DEPTH - 1) : first_q - 1'b1;
  assign next_first = (first_q == AW'(DEPTH - 1)) ? '0 : first_q + 1'b1;
  assign push_sum   = SW'(first_q) + SW'(count_q);
  assign push_slot  = (push_sum >= SW'(DEPTH)) ? AW'(push_sum - SW'(DEPTH))
                                               : AW'(push_sum);
  assign last_sum   = SW'(first_q) + SW'(count_q) - 1'b1;
  assign last_slot  = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH))
                                               : AW'(last_sum);

  // front end maps to the physical head unless reversed
  assign at_head = ((req == dqr_pkg::REQ_PUSH_FRONT) ||
                    (req == dqr_pkg::REQ_POP_FRONT)) != rev_q;
  assign wr_addr = at_head ? prev_first : push_slot;

  // state register and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dqr_pkg::FSM_IDLE;
      first_q   <= '0;
      count_q   <= '0;
      rev_q     <= 1'b0;
      status_q  <= dqr_pkg::ST_DONE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      first_q   <= first_d;
      count_q   <= count_d;
      rev_q     <= rev_d;
      status_q  <= status_d;
      m_valid_q <= m_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // next state, request decode and result load
  always_comb begin
    state_d       = state_q;
    first_d       = first_q;
    count_d       = count_q;
    rev_d         = rev_q;
    status_d      = status_q;
    out_d         = out_q;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    s_axis_tready = 1'b0;
    m_valid_d     = (m_valid_q && m_axis_tready) ? 1'b0 : m_valid_q;
    case (state_q)
      dqr_pkg::FSM_IDLE: begin
        s_axis_tready = !m_valid_q || m_axis_tready;
        if (accept) begin
          state_d  = dqr_pkg::FSM_READ;
          status_d = dqr_pkg::ST_DONE;
          case (req)
            dqr_pkg::REQ_PUSH_FRONT, dqr_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                status_d = dqr_pkg::ST_FULL_DROP;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + 1'b1;
                if (at_head) begin
                  first_d = prev_first;
                end
              end
            end
            dqr_pkg::REQ_POP_FRONT, dqr_pkg::REQ_POP_BACK: begin
              if (empty) begin
                status_d = dqr_pkg::ST_EMPTY_POP;
              end else begin
                count_d = count_q - 1'b1;
                if (at_head) begin
                  first_d = next_first;
                end
              end
            end
            dqr_pkg::REQ_REVERSE: begin
              rev_d = !rev_q;
            end
            dqr_pkg::REQ_CLEAR: begin
              first_d = '0;
              count_d = '0;
              rev_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      dqr_pkg::FSM_READ: begin
        rd_en   = 1'b1;
        state_d = dqr_pkg::FSM_RESP;
      end
      dqr_pkg::FSM_RESP: begin
        out_d     = {status_q, dqr_pkg::TotalWidth'(count_q), empty, back_val, front_val};
        m_valid_d = 1'b1;
        state_d   = dqr_pkg::FSM_IDLE;
      end
      default: begin
        state_d = dqr_pkg::FSM_IDLE;
      end
    endcase
  end

  // head and tail reads after the update
  dqr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (s_axis_tdata),
    .rd_en_i     (rd_en),
    .rd_a_addr_i (first_q),
    .rd_b_addr_i (last_slot),
    .rd_a_data_o (head_val),
    .rd_b_data_o (tail_val)
  );

  // logical ends, zero when empty
  assign front_val = empty ? '0 : (rev_q ? tail_val : head_val);
  assign back_val  = empty ? '0 : (rev_q ? head_val : tail_val);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  `DQR_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `DQR_ASSERT(a_first_bound, first_q <= AW'(DEPTH - 1))
  `DQR_ASSERT_ALWAYS(a_no_result_after_reset, !rst_ni |=> !m_axis_tvalid)
  `DQR_ASSERT(a_one_at_a_time, accept |=> !s_axis_tready)
  `DQR_ASSERT(a_result_slot_free, (state_q == dqr_pkg::FSM_RESP) |-> !m_valid_q)

endmodule

// ===== design/dqr_ram.sv =====
`timescale 1ns / 1ps
module dqr_ram #(
  parameter int unsigned DEPTH = dqr_pkg::DefaultDepth,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [dqr_pkg::ValueWidth-1:0] wr_data_i,
  input  logic                           rd_en_i,
  input  logic [AW-1:0]                  rd_a_addr_i,
  input  logic [AW-1:0]                  rd_b_addr_i,
  output logic [dqr_pkg::ValueWidth-1:0] rd_a_data_o,
  output logic [dqr_pkg::ValueWidth-1:0] rd_b_data_o
);

  logic [dqr_pkg::ValueWidth-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_data_o <= mem_q[rd_a_addr_i];
      rd_b_data_o <= mem_q[rd_b_addr_i];
    end
  end

endmodule
